// File: design/k_weighting_biquad_cascade_macros.svh
// Assertion macros for the K-weighting filter.
// Expects clk and arst_n in the scope of each use.
`ifndef K_WEIGHTING_BIQUAD_CASCADE_MACROS_SVH
`define K_WEIGHTING_BIQUAD_CASCADE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define KWB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kwb check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define KWB_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kwb check failed: same-cycle property");

`endif

// File: design/kwb_pkg.sv
// Shared types and constants for the K-weighting filter.
// No dependencies; used by every module of the block.
package kwb_pkg;

	localparam int COEF_BITS    = 32;
	localparam int STATE_BITS   = 56;
	localparam int NUM_REGS     = 8;
	localparam int REG_IDX_BITS = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_SHELF_B0,
		REG_SHELF_B1,
		REG_SHELF_B2,
		REG_SHELF_A1,
		REG_SHELF_A2,
		REG_HP_GAIN,
		REG_HP_A1,
		REG_HP_A2
	} reg_idx_t;

	typedef logic signed [COEF_BITS-1:0] coef_word_t;

	typedef struct packed {
		coef_word_t shelf_b0;
		coef_word_t shelf_b1;
		coef_word_t shelf_b2;
		coef_word_t shelf_a1;
		coef_word_t shelf_a2;
		coef_word_t hp_gain;
		coef_word_t hp_a1;
		coef_word_t hp_a2;
	} coef_t;

	localparam coef_word_t RST_SHELF_B0 = 32'sd412081942;
	localparam coef_word_t RST_SHELF_B1 = -32'sd722546694;
	localparam coef_word_t RST_SHELF_B2 = 32'sd321691121;
	localparam coef_word_t RST_SHELF_A1 = -32'sd453832899;
	localparam coef_word_t RST_SHELF_A2 = 32'sd196623811;
	localparam coef_word_t RST_HP_GAIN  = 32'sd267101332;
	localparam coef_word_t RST_HP_A1    = -32'sd534199174;
	localparam coef_word_t RST_HP_A2    = 32'sd265770429;

	typedef logic signed [STATE_BITS-1:0] state_word_t;

	typedef struct packed {
		state_word_t shelf_one;
		state_word_t shelf_two;
		state_word_t hp_one;
		state_word_t hp_two;
	} filt_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

// File: design/kwb_ifs.sv
// Valid/ready channel interfaces for sample words and result words.
// No dependencies.
interface kwb_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          chan;
	logic                          first;

	modport source (output valid, output sample_in, output chan, output first, input ready);
	modport sink (input valid, input sample_in, input chan, input first, output ready);
endinterface

interface kwb_result_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] weighted;
	logic                          chan_out;
	logic                          clipped;

	modport source (output valid, output weighted, output chan_out, output clipped, input ready);
	modport sink (input valid, input weighted, input chan_out, input clipped, output ready);
endinterface

// File: design/k_weighting_biquad_cascade.sv
// K-weighting filter: a high-shelf biquad followed by a high-pass biquad, both
// transposed direct form II, with per-channel state kept in a CHANNELS-deep
// state memory (registered read, reset to zero through per-entry valid bits, so
// no clearing pass follows reset). One sample word is in work at a time: read
// the channel state, form the ten products of the two sections on a single
// shared multiplier, write the state back and load the result register once
// the output register is free, then go idle. A finished result waits in the
// output register while the next sample runs. Setting first clears that
// channel's state before filtering. Depends on kwb_pkg, kwb_ifs, the macros.
// Coefficients are signed Q3.28 registers, which the user must write through
// cfg_we/cfg_index/cfg_data while no sample is in work; it is not enforced.
`include "k_weighting_biquad_cascade_macros.svh"

module k_weighting_biquad_cascade #(
	parameter int CHANNELS       = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                             clk,
	input  logic                             arst_n,
	kwb_sample_if.sink                       samples,
	kwb_result_if.source                     results,
	input  logic                             cfg_we,
	input  logic [kwb_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [kwb_pkg::COEF_BITS-1:0]    cfg_data
);
	import kwb_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	coef_t                         coef;
	mem_ctl_t                      mem_ctl;
	logic [AW-1:0]                 mem_addr;
	filt_state_t                   mem_wdata;
	filt_state_t                   mem_rdata;
	logic                          eng_busy;
	logic                          eng_done;
	logic signed [SAMPLE_BITS-1:0] eng_y;
	logic                          eng_clip;
	logic                          eng_chan;
	logic                          res_free;
	logic                          start;

	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] weighted_q;
	logic                          chan_q;
	logic                          clip_q;

	kwb_coef_regs u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.coef   (coef)
	);

	kwb_state_mem #(.CHANNELS(CHANNELS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	kwb_engine #(
		.CHANNELS       (CHANNELS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.start     (start),
		.x_in      (samples.sample_in),
		.chan_in   (samples.chan),
		.first_in  (samples.first),
		.res_free  (res_free),
		.busy      (eng_busy),
		.done      (eng_done),
		.y         (eng_y),
		.clip      (eng_clip),
		.chan_out  (eng_chan),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	assign samples.ready = !eng_busy;
	assign start         = samples.valid && !eng_busy;
	assign res_free      = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (eng_done) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			weighted_q <= eng_y;
			chan_q     <= eng_chan;
			clip_q     <= eng_clip;
		end
	end

	assign results.valid    = out_vld_q;
	assign results.weighted = weighted_q;
	assign results.chan_out = chan_q;
	assign results.clipped  = clip_q;

	`KWB_ASSERT_NEXT(a_one_word_in_work, samples.valid && samples.ready, !samples.ready)
	`KWB_ASSERT_NEXT(a_done_loads_result, eng_done, results.valid)
	`KWB_ASSERT_NOW(a_mem_single_port, mem_ctl.rd, !mem_ctl.wr)
	`KWB_ASSERT_NOW(a_no_result_overwrite, eng_done, !out_vld_q || results.ready)

endmodule

// File: design/kwb_coef_regs.sv
// Coefficient register bank written through the plain configuration port.
// Depends on kwb_pkg.
module kwb_coef_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [kwb_pkg::REG_IDX_BITS-1:0]    index,
	input  logic [kwb_pkg::COEF_BITS-1:0]       data,
	output kwb_pkg::coef_t                      coef
);
	import kwb_pkg::*;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.shelf_b0 <= RST_SHELF_B0;
			coef_q.shelf_b1 <= RST_SHELF_B1;
			coef_q.shelf_b2 <= RST_SHELF_B2;
			coef_q.shelf_a1 <= RST_SHELF_A1;
			coef_q.shelf_a2 <= RST_SHELF_A2;
			coef_q.hp_gain  <= RST_HP_GAIN;
			coef_q.hp_a1    <= RST_HP_A1;
			coef_q.hp_a2    <= RST_HP_A2;
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_SHELF_B0: coef_q.shelf_b0 <= data;
				REG_SHELF_B1: coef_q.shelf_b1 <= data;
				REG_SHELF_B2: coef_q.shelf_b2 <= data;
				REG_SHELF_A1: coef_q.shelf_a1 <= data;
				REG_SHELF_A2: coef_q.shelf_a2 <= data;
				REG_HP_GAIN:  coef_q.hp_gain  <= data;
				REG_HP_A1:    coef_q.hp_a1    <= data;
				REG_HP_A2:    coef_q.hp_a2    <= data;
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// File: design/kwb_state_mem.sv
// Per-channel filter state memory, registered read, one port.
// Entries never written since reset read as zero. Depends on kwb_pkg.
module kwb_state_mem #(
	parameter  int CHANNELS = 2,
	localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kwb_pkg::mem_ctl_t     ctl,
	input  logic [AW-1:0]         addr,
	input  kwb_pkg::filt_state_t  wdata,
	output kwb_pkg::filt_state_t  rdata
);
	import kwb_pkg::*;

	filt_state_t         mem_q [CHANNELS];
	filt_state_t         rdata_q;
	logic [CHANNELS-1:0] vld_q;
	logic                rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvld_q <= vld_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: design/kwb_engine.sv
// Sequencer and shared multiply-accumulate datapath for both biquads.
// Reads channel state, runs ten products, writes state back. Depends on kwb_pkg.
module kwb_engine #(
	parameter  int CHANNELS       = 2,
	parameter  int SAMPLE_BITS    = 24,
	parameter  int COEF_FRAC_BITS = 28,
	localparam int AW             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kwb_pkg::coef_t                coef,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	input  logic                          chan_in,
	input  logic                          first_in,
	input  logic                          res_free,
	output logic                          busy,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] y,
	output logic                          clip,
	output logic                          chan_out,
	output kwb_pkg::mem_ctl_t             mem_ctl,
	output logic [AW-1:0]                 mem_addr,
	output kwb_pkg::filt_state_t          mem_wdata,
	input  kwb_pkg::filt_state_t          mem_rdata
);
	import kwb_pkg::*;

	localparam int MID_BITS = (SAMPLE_BITS + 4 > 32) ? 32 : SAMPLE_BITS + 4;
	localparam int CW       = COEF_BITS + 2;
	localparam int PW       = CW + MID_BITS;
	localparam int SUMW     = ((PW > STATE_BITS) ? PW : STATE_BITS) + 2;

	localparam logic signed [SUMW-1:0] ST_MAX =
		{{(SUMW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [SUMW-1:0] ST_MIN = ~ST_MAX;
	localparam logic signed [SUMW-1:0] MID_MAX =
		{{(SUMW-MID_BITS+1){1'b0}}, {(MID_BITS-1){1'b1}}};
	localparam logic signed [SUMW-1:0] MID_MIN = ~MID_MAX;
	localparam logic signed [SUMW-1:0] SMP_MAX =
		{{(SUMW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SMP_MIN = ~SMP_MAX;
	localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (COEF_FRAC_BITS - 1);

	localparam logic [2:0] PH_B0   = 3'd0;
	localparam logic [2:0] PH_B1   = 3'd1;
	localparam logic [2:0] PH_B2   = 3'd2;
	localparam logic [2:0] PH_A1   = 3'd3;
	localparam logic [2:0] PH_A2   = 3'd4;
	localparam logic [2:0] PH_LAST = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_RUN,
		S_DONE
	} st_t;

	function automatic state_word_t sat_st(input logic signed [SUMW-1:0] v);
		if (v > ST_MAX) begin
			return ST_MAX[STATE_BITS-1:0];
		end else if (v < ST_MIN) begin
			return ST_MIN[STATE_BITS-1:0];
		end
		return v[STATE_BITS-1:0];
	endfunction

	function automatic logic signed [SUMW-1:0] rnd_shift(input state_word_t a);
		logic signed [SUMW-1:0] r;
		r = SUMW'(a) + RND;
		return r >>> COEF_FRAC_BITS;
	endfunction

	function automatic logic [AW-1:0] chan_idx(input logic c);
		return (CHANNELS > 1) ? AW'(c) : '0;
	endfunction

	st_t        st_q;
	logic       stg_q;
	logic [2:0] ph_q;
	logic       chan_q;
	logic       first_q;

	logic signed [MID_BITS-1:0] w_q;
	logic signed [MID_BITS-1:0] yw_q;
	logic signed [PW-1:0]       prod_q;
	state_word_t                acc_q;
	state_word_t                t1_q;
	state_word_t                t2_q;
	state_word_t                s1_q;
	state_word_t                s2_q;
	state_word_t                h1_q;
	state_word_t                h2_q;

	logic signed [CW-1:0]       neg2g;
	logic signed [CW-1:0]       mul_c;
	logic signed [MID_BITS-1:0] mul_w;
	state_word_t                prod_st;
	state_word_t                za;
	state_word_t                zb;
	logic signed [SUMW-1:0]     q_rnd;
	logic signed [MID_BITS-1:0] yw_d;
	logic                       take;

	assign take = (st_q == S_IDLE) && start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			stg_q   <= 1'b0;
			ph_q    <= PH_B0;
			chan_q  <= 1'b0;
			first_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						st_q    <= S_READ;
						chan_q  <= chan_in;
						first_q <= first_in;
					end
				end
				S_READ: begin
					st_q  <= S_RUN;
					stg_q <= 1'b0;
					ph_q  <= PH_B0;
				end
				S_RUN: begin
					if (ph_q == PH_LAST) begin
						ph_q  <= PH_B0;
						stg_q <= ~stg_q;
						if (stg_q) begin
							st_q <= S_DONE;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DONE: begin
					if (res_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign neg2g = CW'(0) - (CW'($signed(coef.hp_gain)) <<< 1);

	always_comb begin
		case (ph_q)
			PH_B0:   mul_c = stg_q ? CW'($signed(coef.hp_gain)) : CW'($signed(coef.shelf_b0));
			PH_B1:   mul_c = stg_q ? neg2g : CW'($signed(coef.shelf_b1));
			PH_B2:   mul_c = stg_q ? CW'($signed(coef.hp_gain)) : CW'($signed(coef.shelf_b2));
			PH_A1:   mul_c = stg_q ? CW'($signed(coef.hp_a1)) : CW'($signed(coef.shelf_a1));
			default: mul_c = stg_q ? CW'($signed(coef.hp_a2)) : CW'($signed(coef.shelf_a2));
		endcase
	end

	assign mul_w   = (ph_q == PH_A1 || ph_q == PH_A2) ? yw_q : w_q;
	assign prod_st = sat_st(SUMW'(prod_q));
	assign za      = stg_q ? h1_q : s1_q;
	assign zb      = stg_q ? h2_q : s2_q;
	assign q_rnd   = rnd_shift(acc_q);

	always_comb begin
		if (q_rnd > MID_MAX) begin
			yw_d = MID_MAX[MID_BITS-1:0];
		end else if (q_rnd < MID_MIN) begin
			yw_d = MID_MIN[MID_BITS-1:0];
		end else begin
			yw_d = q_rnd[MID_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= MID_BITS'(x_in);
		end
		if (st_q == S_READ) begin
			if (first_q) begin
				{s1_q, s2_q, h1_q, h2_q} <= '0;
			end else begin
				s1_q <= mem_rdata.shelf_one;
				s2_q <= mem_rdata.shelf_two;
				h1_q <= mem_rdata.hp_one;
				h2_q <= mem_rdata.hp_two;
			end
		end
		if (st_q == S_RUN) begin
			prod_q <= mul_c * mul_w;
			case (ph_q)
				PH_B1: acc_q <= sat_st(SUMW'(prod_st) + SUMW'(za));
				PH_B2: begin
					yw_q <= yw_d;
					t1_q <= prod_st;
				end
				PH_A1: t2_q <= prod_st;
				PH_A2: t1_q <= sat_st(SUMW'(t1_q) - SUMW'(prod_st) + SUMW'(zb));
				PH_LAST: begin
					if (stg_q) begin
						h1_q <= t1_q;
						h2_q <= sat_st(SUMW'(t2_q) - SUMW'(prod_st));
					end else begin
						s1_q <= t1_q;
						s2_q <= sat_st(SUMW'(t2_q) - SUMW'(prod_st));
						w_q  <= yw_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy     = (st_q != S_IDLE);
	assign done     = (st_q == S_DONE) && res_free;
	assign clip     = (q_rnd > SMP_MAX) || (q_rnd < SMP_MIN);
	assign y        = (q_rnd > SMP_MAX) ? SMP_MAX[SAMPLE_BITS-1:0] :
	                  (q_rnd < SMP_MIN) ? SMP_MIN[SAMPLE_BITS-1:0] : q_rnd[SAMPLE_BITS-1:0];
	assign chan_out = chan_q;

	assign mem_ctl.rd = take;
	assign mem_ctl.wr = done;
	assign mem_addr   = (st_q == S_IDLE) ? chan_idx(chan_in) : chan_idx(chan_q);

	assign mem_wdata.shelf_one = s1_q;
	assign mem_wdata.shelf_two = s2_q;
	assign mem_wdata.hp_one    = h1_q;
	assign mem_wdata.hp_two    = h2_q;

endmodule

// File: tb/tb.sv
// Testbench for k_weighting_biquad_cascade: a directed table, then random phases across
// several coefficient sets; results checked against literals or a fixed-point predictor.
// Depends on kwb_pkg, the kwb_ifs channel interfaces and the block's RTL.
module tb;
	import kwb_pkg::*;

	localparam int CHANNELS      = 2;
	localparam int SAMP_BITS     = 24;
	localparam int FRAC_BITS     = 28;
	localparam int MID_BITS      = 28;
	localparam int PHASE_WORDS   = 200;
	localparam int NUM_PHASES    = 7;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 300;

	typedef logic signed [SAMP_BITS-1:0] sample_t;
	typedef coef_word_t coef_set_t [NUM_REGS];

	typedef struct packed {
		sample_t weighted;
		logic    chan_out;
		logic    clipped;
	} kw_word_t;

	typedef enum logic {ROW_WORD, ROW_COEFS} row_kind_e;
	typedef enum logic [2:0] {PRE_RESET, PRE_UNITY, PRE_DOUBLE, PRE_TOP, PRE_BOTTOM} preset_e;

	typedef struct packed {
		row_kind_e kind;
		preset_e   preset;
		sample_t   sample;
		logic      chan;
		logic      first;
		logic      lit;
		sample_t   exp_weighted;
		logic      exp_clipped;
	} dir_row_t;

	localparam sample_t S_MAX = 24'sh7FFFFF;
	localparam sample_t S_MIN = 24'sh800000;
	localparam int DIR_LEN = 24;

	localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
		'{ROW_WORD,  PRE_RESET,  24'sd0,       1'b0, 1'b1, 1'b1, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  24'sd0,       1'b1, 1'b1, 1'b1, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b0, 1'b1, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MIN,        1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b1, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  -24'sd1,      1'b1, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_COEFS, PRE_UNITY,  24'sd0,       1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b0, 1'b1, 1'b1, S_MAX,        1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MIN,        1'b1, 1'b1, 1'b1, S_MIN,        1'b0},
		'{ROW_WORD,  PRE_RESET,  24'sd1,       1'b0, 1'b1, 1'b1, 24'sd1,       1'b0},
		'{ROW_WORD,  PRE_RESET,  -24'sd1,      1'b1, 1'b1, 1'b1, -24'sd1,      1'b0},
		'{ROW_WORD,  PRE_RESET,  24'sh555555,  1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_COEFS, PRE_DOUBLE, 24'sd0,       1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b0, 1'b1, 1'b1, S_MAX,        1'b1},
		'{ROW_WORD,  PRE_RESET,  S_MIN,        1'b1, 1'b1, 1'b1, S_MIN,        1'b1},
		'{ROW_WORD,  PRE_RESET,  24'sh400000,  1'b0, 1'b1, 1'b1, S_MAX,        1'b1},
		'{ROW_WORD,  PRE_RESET,  24'sh3FFFFF,  1'b1, 1'b1, 1'b1, 24'sh7FFFFE,  1'b0},
		'{ROW_COEFS, PRE_TOP,    24'sd0,       1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b0, 1'b1, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MIN,        1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  24'sh2AAAAA,  1'b1, 1'b1, 1'b0, 24'sd0,       1'b0},
		'{ROW_COEFS, PRE_BOTTOM, 24'sd0,       1'b0, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MAX,        1'b1, 1'b1, 1'b0, 24'sd0,       1'b0},
		'{ROW_WORD,  PRE_RESET,  S_MIN,        1'b1, 1'b0, 1'b0, 24'sd0,       1'b0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [REG_IDX_BITS-1:0] cfg_index;
	logic [COEF_BITS-1:0]    cfg_data;

	kwb_sample_if #(.SAMPLE_BITS(SAMP_BITS)) samp_ch ();
	kwb_result_if #(.SAMPLE_BITS(SAMP_BITS)) res_ch ();

	k_weighting_biquad_cascade #(
		.CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMP_BITS),
		.COEF_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samp_ch),
		.results(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	coef_set_t  rst_set;
	coef_word_t coef_shadow [NUM_REGS];
	longint     shelf_z1 [CHANNELS];
	longint     shelf_z2 [CHANNELS];
	longint     hp_z1 [CHANNELS];
	longint     hp_z2 [CHANNELS];
	kw_word_t   weighted_q [$];
	int         err_cnt;
	int         n_in;
	int         n_out;
	int         n_clipped;
	int         n_coef_sets;
	bit         send_busy;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clamp(input longint v, input int bits, output bit hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		hit = (v > hi) || (v < lo);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint prod56(input longint c, input longint w);
		bit hit;
		return clamp(c * w, STATE_BITS, hit);
	endfunction

	function automatic longint round_word(input longint acc, input int bits, output bit hit);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return clamp(q, bits, hit);
	endfunction

	function automatic longint biquad_tdf2(input longint x, input longint b0, input longint b1,
			input longint b2, input longint a1, input longint a2,
			inout longint z1, inout longint z2);
		bit hit;
		longint acc;
		longint yw;
		acc = clamp(prod56(b0, x) + z1, STATE_BITS, hit);
		yw = round_word(acc, MID_BITS, hit);
		z1 = clamp(prod56(b1, x) - prod56(a1, yw) + z2, STATE_BITS, hit);
		z2 = clamp(prod56(b2, x) - prod56(a2, yw), STATE_BITS, hit);
		return acc;
	endfunction

	function automatic kw_word_t k_weight(input sample_t s, input logic c, input logic f);
		int ch;
		bit hit;
		longint g;
		longint acc;
		longint mid;
		longint y;
		kw_word_t res;
		ch = int'(c) % CHANNELS;
		if (f) begin
			shelf_z1[ch] = 0;
			shelf_z2[ch] = 0;
			hp_z1[ch] = 0;
			hp_z2[ch] = 0;
		end
		acc = biquad_tdf2(longint'(s), coef_shadow[REG_SHELF_B0], coef_shadow[REG_SHELF_B1],
			coef_shadow[REG_SHELF_B2], coef_shadow[REG_SHELF_A1], coef_shadow[REG_SHELF_A2],
			shelf_z1[ch], shelf_z2[ch]);
		mid = round_word(acc, MID_BITS, hit);
		g = longint'(coef_shadow[REG_HP_GAIN]);
		acc = biquad_tdf2(mid, g, -2 * g, g, coef_shadow[REG_HP_A1], coef_shadow[REG_HP_A2],
			hp_z1[ch], hp_z2[ch]);
		y = round_word(acc, SAMP_BITS, hit);
		res.weighted = y[SAMP_BITS-1:0];
		res.chan_out = c;
		res.clipped = hit;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic write_coefs(input coef_set_t cs);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= cs[i];
			@(posedge clk);
			coef_shadow[i] = cs[i];
		end
		cfg_we <= 1'b0;
		n_coef_sets++;
	endtask

	task automatic load_preset(input preset_e p);
		coef_set_t cs;
		case (p)
			PRE_RESET: cs = rst_set;
			PRE_UNITY: cs = '{32'sh1000_0000, 0, 0, 0, 0, 32'sh1000_0000, 0, 0};
			PRE_DOUBLE: cs = '{32'sh2000_0000, 0, 0, 0, 0, 32'sh1000_0000, 0, 0};
			PRE_TOP: cs = '{default: 32'sh7FFF_FFFF};
			default: cs = '{default: 32'sh8000_0000};
		endcase
		write_coefs(cs);
	endtask

	task automatic drain();
		samp_ch.valid <= 1'b0;
		while (weighted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_word(input sample_t s, input logic c, input logic f, input bit lit,
			input kw_word_t lit_word);
		int gap;
		kw_word_t want;
		gap = send_busy ? 0 : pick_gap();
		if (gap > 0) begin
			samp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samp_ch.valid <= 1'b1;
		samp_ch.sample_in <= s;
		samp_ch.chan <= c;
		samp_ch.first <= f;
		@(posedge clk);
		while (!samp_ch.ready)
			@(posedge clk);
		want = k_weight(s, c, f);
		weighted_q.insert(weighted_q.size(), lit ? lit_word : want);
		n_in++;
	endtask

	initial begin
		coef_set_t cs;
		sample_t s;
		logic c;
		logic f;
		logic [31:0] raw;
		bit started [CHANNELS];
		int r;
		kw_word_t lit_word;
		rst_set = '{RST_SHELF_B0, RST_SHELF_B1, RST_SHELF_B2, RST_SHELF_A1, RST_SHELF_A2,
			RST_HP_GAIN, RST_HP_A1, RST_HP_A2};
		coef_shadow = rst_set;
		for (int i = 0; i < CHANNELS; i++) begin
			shelf_z1[i] = 0;
			shelf_z2[i] = 0;
			hp_z1[i] = 0;
			hp_z2[i] = 0;
		end
		err_cnt = 0;
		n_in = 0;
		n_out = 0;
		n_clipped = 0;
		n_coef_sets = 0;
		send_busy = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SHELF_B0;
		cfg_data <= '0;
		samp_ch.valid <= 1'b0;
		samp_ch.sample_in <= '0;
		samp_ch.chan <= 1'b0;
		samp_ch.first <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_LEN; i++) begin
			if (DIR_ROWS[i].kind == ROW_COEFS) begin
				drain();
				load_preset(DIR_ROWS[i].preset);
			end else begin
				lit_word.weighted = DIR_ROWS[i].exp_weighted;
				lit_word.chan_out = DIR_ROWS[i].chan;
				lit_word.clipped = DIR_ROWS[i].exp_clipped;
				put_word(DIR_ROWS[i].sample, DIR_ROWS[i].chan, DIR_ROWS[i].first,
					DIR_ROWS[i].lit, lit_word);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			send_busy = (ph == 3);
			case (ph)
				0, 3: load_preset(PRE_RESET);
				5: load_preset(PRE_UNITY);
				default: begin
					for (int i = 0; i < NUM_REGS; i++) begin
						if (ph == 2)
							cs[i] = $urandom;
						else if (ph == 4)
							cs[i] = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
						else
							cs[i] = rst_set[i] + int'($urandom_range(1 << 20)) - (1 << 19);
					end
					write_coefs(cs);
				end
			endcase
			started = '{default: 1'b0};
			for (int w = 0; w < PHASE_WORDS; w++) begin
				if (ph == 2 && w == PHASE_WORDS / 2)
					drain();
				c = $urandom_range(1);
				f = !started[c] || ($urandom_range(99) < 3);
				started[c] = 1'b1;
				r = $urandom_range(99);
				if (r < 65) begin
					raw = $urandom;
					s = raw[SAMP_BITS-1:0];
				end else if (r < 85) begin
					s = sample_t'(int'($urandom_range(2000)) - 1000);
				end else begin
					case ($urandom_range(3))
						0: s = S_MAX;
						1: s = S_MIN;
						2: s = '0;
						default: s = -24'sd1;
					endcase
				end
				put_word(s, c, f, 1'b0, '0);
			end
		end
		drain();

		$display("tb: %0d sample words sent, %0d result words checked, %0d of them clipped",
			n_in, n_out, n_clipped);
		$display("tb: %0d coefficient sets loaded, %0d mismatches", n_coef_sets, err_cnt);
		if (err_cnt == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		int gap_left;
		int calm_left;
		int hold_left;
		int r;
		kw_word_t want;
		gap_left = 0;
		calm_left = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (weighted_q.size() == 0) begin
					err_cnt++;
					$error("result word with nothing expected: weighted %0d chan_out %0d",
						res_ch.weighted, res_ch.chan_out);
				end else begin
					want = weighted_q.pop_front();
					if (res_ch.weighted !== want.weighted) begin
						err_cnt++;
						$error("weighted: expected %0d, got %0d", want.weighted, res_ch.weighted);
					end
					if (res_ch.chan_out !== want.chan_out) begin
						err_cnt++;
						$error("chan_out: expected %0d, got %0d", want.chan_out, res_ch.chan_out);
					end
					if (res_ch.clipped !== want.clipped) begin
						err_cnt++;
						$error("clipped: expected %0d, got %0d", want.clipped, res_ch.clipped);
					end
					if (res_ch.clipped === 1'b1)
						n_clipped++;
				end
				n_out++;
				// hold off long enough for the block to back up into its input
				if (n_out == 300 || n_out == 900)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				res_ch.ready <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				res_ch.ready <= 1'b0;
			end else begin
				r = $urandom_range(999);
				if (r < 4)
					calm_left = 150;
				else if (r < 30)
					gap_left = $urandom_range(60, 20);
				else if (r < 260)
					gap_left = $urandom_range(3, 1);
				res_ch.ready <= (gap_left == 0);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/kwb_pkg.sv
design/kwb_ifs.sv
design/kwb_coef_regs.sv
design/kwb_state_mem.sv
design/kwb_engine.sv
design/k_weighting_biquad_cascade.sv
tb/tb.sv
